// File: hw/rtl/urhr_pkg.sv
// Shared types, constants and ring pointer helpers for the undo/redo history ring.
// No dependencies; imported by the core and by its port checker.
package urhr_pkg;

   localparam int HISTORY_DEPTH = 128;
   localparam int PAYLOAD_WIDTH = 64;
   localparam int ACTIVE_WIDTH  = 4;
   localparam int PTR_WIDTH     = $clog2(HISTORY_DEPTH);

   typedef logic [PTR_WIDTH-1:0]     ptr_type;
   typedef logic [PAYLOAD_WIDTH-1:0] payload_type;
   typedef logic [ACTIVE_WIDTH-1:0]  active_type;

   // Command codes carried in the op field of a request.
   typedef enum logic [1:0] {
      OP_SNAPSHOT = 2'd0,
      OP_UNDO     = 2'd1,
      OP_REDO     = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   // One history slot as held in the slot memory.
   typedef struct packed {
      active_type  active;
      payload_type data;
   } slot_type;

   // Step one slot forward around the ring.
   function automatic ptr_type ring_next(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(HISTORY_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

   // Step one slot backward around the ring.
   function automatic ptr_type ring_prev(input ptr_type p);
      ptr_type r;
      if (p == '0) begin
         r = ptr_type'(HISTORY_DEPTH - 1);
      end else begin
         r = p - ptr_type'(1);
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/undo_redo_history_ring_core.sv
// Undo/redo history ring: slot memory, empty marks, ring pointers and the
// request and response registers. Depends on urhr_pkg.
//
// The block takes one request per clock cycle unless its input is stalled, and
// returns exactly one response per request, in order. An accepted request is held
// in the input register, where it updates the pointers and empty marks; as it
// leaves that register, the single-port slot memory is written (snapshot) or read
// (undo, redo), and the registered read data and the flags form the response in
// the output register. Empty marks live in flip-flops, so a clear takes effect at
// once and the block needs no clearing pass after reset. A response waiting in the
// output register does not stop the next request from entering an empty input
// register; the request side is stalled only while both registers are full and
// the response side is stalled.
module undo_redo_history_ring_core
   import urhr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_op,
   input  logic [PAYLOAD_WIDTH-1:0] req_snap_data,
   input  logic [ACTIVE_WIDTH-1:0]  req_snap_active,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_restored,
   output logic [PAYLOAD_WIDTH-1:0] rsp_restored_data,
   output logic [ACTIVE_WIDTH-1:0]  rsp_restored_active,
   output logic                     rsp_can_undo,
   output logic                     rsp_can_redo
);

   // Input register.
   logic        s1_valid_ff;
   op_type      s1_op_ff;
   payload_type s1_data_ff;
   active_type  s1_active_ff;

   // Ring state.
   logic [HISTORY_DEPTH-1:0] empty_ff;
   logic [HISTORY_DEPTH-1:0] empty_in;
   ptr_type                  oldest_ff;
   ptr_type                  oldest_in;
   ptr_type                  cursor_ff;
   ptr_type                  cursor_in;

   // Slot memory and its registered read data.
   slot_type slot_mem [HISTORY_DEPTH];
   slot_type rd_ff;

   // Response register.
   logic rsp_valid_ff;
   logic hit_ff;
   logic can_undo_ff;
   logic can_redo_ff;

   logic advance;
   logic s1_fire;
   logic mem_wr;
   logic hit;
   logic can_undo_in;
   logic can_redo_in;

   // The input register moves on whenever the output register is free or drains.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;

   // Next ring state and response flags for the request in the input register.
   always_comb begin
      ptr_type newest;
      ptr_type after_cursor;
      newest       = ring_prev(oldest_ff);
      cursor_in    = cursor_ff;
      oldest_in    = oldest_ff;
      empty_in     = empty_ff;
      mem_wr       = 1'b0;
      hit          = 1'b0;
      after_cursor = '0;
      case (s1_op_ff)
         OP_SNAPSHOT: begin
            // A filled cursor slot pushes the cursor on; on a full ring the
            // oldest entry is dropped.
            if (!empty_ff[cursor_ff]) begin
               if (cursor_ff == newest) begin
                  oldest_in = ring_next(oldest_ff);
               end
               cursor_in = ring_next(cursor_ff);
            end
            mem_wr              = 1'b1;
            empty_in[cursor_in] = 1'b0;
            // Empty the following slot so that redo is cut off.
            after_cursor = ring_next(cursor_in);
            if (after_cursor != oldest_in) begin
               empty_in[after_cursor] = 1'b1;
            end
         end
         OP_UNDO: begin
            if (cursor_ff != oldest_ff) begin
               cursor_in = ring_prev(cursor_ff);
               hit       = !empty_ff[cursor_in];
            end
         end
         OP_REDO: begin
            if (cursor_ff != newest) begin
               cursor_in = ring_next(cursor_ff);
               hit       = !empty_ff[cursor_in];
            end
         end
         OP_CLEAR: begin
            empty_in  = '1;
            cursor_in = oldest_ff;
         end
         default: begin
            cursor_in = cursor_ff;
         end
      endcase
      can_undo_in = (cursor_in != oldest_in) && !empty_in[ring_prev(cursor_in)];
      can_redo_in = (ring_next(cursor_in) != oldest_in)
                    && !empty_in[ring_next(cursor_in)];
   end

   // Control state: handshake valids, empty marks and ring pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         empty_ff     <= '1;
         oldest_ff    <= '0;
         cursor_ff    <= '0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_fire) begin
            empty_ff  <= empty_in;
            oldest_ff <= oldest_in;
            cursor_ff <= cursor_in;
         end
      end
   end

   // Request payload capture.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_op_ff     <= op_type'(req_op);
         s1_data_ff   <= req_snap_data;
         s1_active_ff <= req_snap_active;
      end
   end

   // Response flags.
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         hit_ff      <= hit;
         can_undo_ff <= can_undo_in;
         can_redo_ff <= can_redo_in;
      end
   end

   // Slot memory: at most one access per request, at the new cursor position.
   always_ff @(posedge clock) begin
      if (s1_fire && mem_wr) begin
         slot_mem[cursor_in] <= '{active: s1_active_ff, data: s1_data_ff};
      end
      if (s1_fire && hit) begin
         rd_ff <= slot_mem[cursor_in];
      end
   end

   // Outputs; restored fields read as zero when nothing was restored.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_restored        = hit_ff;
   assign rsp_restored_data   = hit_ff ? rd_ff.data : '0;
   assign rsp_restored_active = hit_ff ? rd_ff.active : '0;
   assign rsp_can_undo        = can_undo_ff;
   assign rsp_can_redo        = can_redo_ff;

endmodule

// File: hw/rtl/urhr_checker.sv
// Port-level checks for the undo/redo history ring core, bound into every core instance.
// Depends on urhr_pkg and undo_redo_history_ring_core.
module urhr_checker
   import urhr_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic [1:0]               req_op,
   input logic [PAYLOAD_WIDTH-1:0] req_snap_data,
   input logic [ACTIVE_WIDTH-1:0]  req_snap_active,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic                     rsp_restored,
   input logic [PAYLOAD_WIDTH-1:0] rsp_restored_data,
   input logic [ACTIVE_WIDTH-1:0]  rsp_restored_active,
   input logic                     rsp_can_undo,
   input logic                     rsp_can_redo
);

   logic seen_rsp_ff;

   // Marks that a response has been delivered since reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_rsp_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         seen_rsp_ff <= 1'b1;
      end
   end

   // The first response after reset comes from an empty ring.
   a_first_rsp_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !seen_rsp_ff |-> !rsp_restored && !rsp_can_undo && !rsp_can_redo)
      else $error("first response after reset reports history");

   // Restored fields are zero whenever nothing was restored.
   a_unrestored_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_restored |-> rsp_restored_data == '0 && rsp_restored_active == '0)
      else $error("restored fields nonzero without a restore");

   // The request side is only held back by a stalled, occupied response side.
   a_stall_only_on_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while the response side is free");

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_restored)
         && $stable(rsp_restored_data) && $stable(rsp_restored_active)
         && $stable(rsp_can_undo) && $stable(rsp_can_redo))
      else $error("stalled response changed");

endmodule

bind undo_redo_history_ring_core urhr_checker u_urhr_checker (.*);

// File: tb/sv/tb_undo_redo_history_ring_core.sv
// Self-checking testbench for the undo/redo history ring core.
// Drives snapshot, undo, redo and clear requests and checks each response.
// Depends on urhr_pkg and undo_redo_history_ring_core.
`timescale 1ns / 100ps

module tb_undo_redo_history_ring_core;
   import urhr_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int MAX_IDLE      = 17;
   localparam int RANDOM_ITEMS  = 450;
   localparam int FILL_ITEMS    = 135;
   localparam int HOLD_OFF      = 90;
   localparam int MAX_REPORTS   = 30;
   localparam int N_DIRECTED    = 22;
   localparam payload_type ALL_ONES = '1;

   // Response fields as the block returns them.
   typedef struct packed {
      logic        restored;
      payload_type rdata;
      active_type  ractive;
      logic        can_undo;
      logic        can_redo;
   } history_rsp_type;

   // One directed request, with a hand-written response where typed is set.
   typedef struct {
      op_type          op;
      payload_type     data;
      active_type      act;
      bit              typed;
      history_rsp_type want;
   } command_row_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [1:0]               req_op;
   logic [PAYLOAD_WIDTH-1:0] req_snap_data;
   logic [ACTIVE_WIDTH-1:0]  req_snap_active;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_restored;
   logic [PAYLOAD_WIDTH-1:0] rsp_restored_data;
   logic [ACTIVE_WIDTH-1:0]  rsp_restored_active;
   logic                     rsp_can_undo;
   logic                     rsp_can_redo;

   // Shadow copy of the history ring.
   payload_type               hist_data [HISTORY_DEPTH];
   active_type                hist_active [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0]  hist_empty;
   ptr_type                   hist_oldest;
   ptr_type                   hist_cursor;

   history_rsp_type pending_rsp [$];
   command_row_type directed_cmds [N_DIRECTED];

   int error_count        = 0;
   int cycle_count        = 0;
   int sender_gap_max     = MAX_IDLE;
   int receiver_gap_max   = MAX_IDLE;
   int hold_off_req       = 0;
   int long_holds         = 0;
   int random_sent        = 0;
   int input_stall_cycles = 0;
   int n_responses        = 0;
   int n_snap             = 0;
   int n_undo             = 0;
   int n_redo             = 0;
   int n_clear            = 0;
   int n_restored         = 0;
   int n_wraps            = 0;
   int n_undo_blocked     = 0;
   int n_redo_blocked     = 0;

   undo_redo_history_ring_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_snap_data       (req_snap_data),
      .req_snap_active     (req_snap_active),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_restored        (rsp_restored),
      .rsp_restored_data   (rsp_restored_data),
      .rsp_restored_active (rsp_restored_active),
      .rsp_can_undo        (rsp_can_undo),
      .rsp_can_redo        (rsp_can_redo)
   );

   // Free-running clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic ptr_type slot_after(input ptr_type p);
      return ptr_type'((int'(p) + 1) % HISTORY_DEPTH);
   endfunction

   function automatic ptr_type slot_before(input ptr_type p);
      return ptr_type'((int'(p) + HISTORY_DEPTH - 1) % HISTORY_DEPTH);
   endfunction

   // Applies one command to the shadow ring and returns the response it should give.
   function automatic history_rsp_type apply_command(input op_type op, input payload_type data,
                                                     input active_type act);
      history_rsp_type r;
      ptr_type         newest;
      logic            moves;
      r = '0;
      newest = slot_before(hist_oldest);
      case (op)
         OP_SNAPSHOT: begin
            n_snap++;
            // A filled cursor slot pushes the cursor on, dropping the oldest entry if full.
            if (!hist_empty[hist_cursor]) begin
               if (hist_cursor == newest) begin
                  hist_oldest = slot_after(hist_oldest);
                  n_wraps++;
               end
               hist_cursor = slot_after(hist_cursor);
            end
            hist_data[hist_cursor]   = data;
            hist_active[hist_cursor] = act;
            hist_empty[hist_cursor]  = 1'b0;
            // Cut off redo past the new entry.
            if (slot_after(hist_cursor) != hist_oldest) begin
               hist_empty[slot_after(hist_cursor)] = 1'b1;
            end
         end
         OP_UNDO, OP_REDO: begin
            if (op == OP_UNDO) begin
               n_undo++;
               moves = (hist_cursor != hist_oldest);
            end else begin
               n_redo++;
               moves = (hist_cursor != newest);
            end
            if (moves) begin
               hist_cursor = (op == OP_UNDO) ? slot_before(hist_cursor) : slot_after(hist_cursor);
               if (!hist_empty[hist_cursor]) begin
                  r.restored = 1'b1;
                  r.rdata    = hist_data[hist_cursor];
                  r.ractive  = hist_active[hist_cursor];
                  n_restored++;
               end
            end else if (op == OP_UNDO) begin
               n_undo_blocked++;
            end else begin
               n_redo_blocked++;
            end
         end
         default: begin
            n_clear++;
            hist_empty  = '1;
            hist_cursor = hist_oldest;
         end
      endcase
      r.can_undo = (hist_cursor != hist_oldest) && !hist_empty[slot_before(hist_cursor)];
      r.can_redo = (slot_after(hist_cursor) != hist_oldest)
                   && !hist_empty[slot_after(hist_cursor)];
      return r;
   endfunction

   function automatic payload_type random_payload();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ALL_ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Mostly legal pattern indexes, with out-of-range ones now and then.
   function automatic active_type random_active();
      if ($urandom_range(0, 4) == 0) begin
         return active_type'($urandom_range(10, 15));
      end
      return active_type'($urandom_range(0, 9));
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         if (error_count < MAX_REPORTS) begin
            $display("%0t ns: %s mismatch, expected 'h%0h, got 'h%0h", $time, name, want, got);
         end
         error_count++;
      end
   endfunction

   // Offers one request after a random gap and records its expected response on acceptance.
   task automatic send_request(input op_type op, input payload_type data, input active_type act,
                               input bit typed, input history_rsp_type want);
      int              gap;
      history_rsp_type predicted;
      gap = (sender_gap_max == 0) ? 0 : $urandom_range(0, sender_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_snap_data   <= data;
      req_snap_active <= act;
      do @(posedge clock); while (req_stall);
      predicted = apply_command(op, data, act);
      pending_rsp.push_back(typed ? want : predicted);
   endtask

   task automatic send_random(input op_type op);
      send_request(op, random_payload(), random_active(), 1'b0, '0);
      random_sent++;
   endtask

   // Lowers valid and waits until every outstanding request has been answered.
   task automatic drain_requests();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Response checker and input stall counter.
   always @(posedge clock) begin : check_responses
      history_rsp_type want;
      if (!reset) begin
         if (req_valid && req_stall) begin
            input_stall_cycles++;
         end
         if (rsp_valid && !rsp_stall) begin
            n_responses++;
            if (pending_rsp.size() == 0) begin
               if (error_count < MAX_REPORTS) begin
                  $display("%0t ns: response with no request pending, expected none, got 'h%0h",
                           $time, rsp_restored_data);
               end
               error_count++;
            end else begin
               want = pending_rsp.pop_front();
               check_field("restored", 64'(want.restored), 64'(rsp_restored));
               check_field("restored_data", want.rdata, rsp_restored_data);
               check_field("restored_active", 64'(want.ractive), 64'(rsp_restored_active));
               check_field("can_undo", 64'(want.can_undo), 64'(rsp_can_undo));
               check_field("can_redo", 64'(want.can_redo), 64'(rsp_can_redo));
            end
         end
      end
   end

   // Overall cycle limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t ns: timeout after %0d cycles with %0d responses outstanding",
                  $time, cycle_count, pending_rsp.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Response side stall: a random hold per response, or one long hold-off on request.
   initial begin : drive_rsp_stall
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         if (hold_off_req > 0) begin
            hold = hold_off_req;
            hold_off_req = 0;
            long_holds++;
         end else begin
            hold = (receiver_gap_max == 0) ? 0 : $urandom_range(0, receiver_gap_max);
         end
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Main stimulus sequence.
   initial begin : run_stimulus
      int     kind;
      int     burst_len;
      int     r;
      op_type op;

      req_valid       <= 1'b0;
      req_op          <= OP_SNAPSHOT;
      req_snap_data   <= '0;
      req_snap_active <= '0;
      reset           <= 1'b1;
      hist_empty  = '1;
      hist_oldest = '0;
      hist_cursor = '0;

      directed_cmds = '{
         // Undo at the oldest slot right after reset, then redo onto an empty slot.
         '{OP_UNDO, '0, 4'h0, 1'b1, '{1'b0, '0, 4'h0, 1'b0, 1'b0}},
         '{OP_REDO, '0, 4'h0, 1'b1, '{1'b0, '0, 4'h0, 1'b0, 1'b0}},
         '{OP_CLEAR, '0, 4'h0, 1'b1, '{1'b0, '0, 4'h0, 1'b0, 1'b0}},
         // Three entries with extreme payloads and indexes.
         '{OP_SNAPSHOT, ALL_ONES, 4'hF, 1'b1, '{1'b0, '0, 4'h0, 1'b0, 1'b0}},
         '{OP_SNAPSHOT, '0, 4'h0, 1'b1, '{1'b0, '0, 4'h0, 1'b1, 1'b0}},
         '{OP_SNAPSHOT, 64'h5555_5555_5555_5555, 4'd9, 1'b1, '{1'b0, '0, 4'h0, 1'b1, 1'b0}},
         // Walk back to the oldest slot and try to step past it.
         '{OP_UNDO, '0, 4'h0, 1'b1, '{1'b1, '0, 4'h0, 1'b1, 1'b1}},
         '{OP_UNDO, '0, 4'h0, 1'b1, '{1'b1, ALL_ONES, 4'hF, 1'b0, 1'b1}},
         '{OP_UNDO, '0, 4'h0, 1'b1, '{1'b0, '0, 4'h0, 1'b0, 1'b1}},
         // Walk forward again and onto the empty slot after the newest entry.
         '{OP_REDO, '0, 4'h0, 1'b1, '{1'b1, '0, 4'h0, 1'b1, 1'b1}},
         '{OP_REDO, '0, 4'h0, 1'b1, '{1'b1, 64'h5555_5555_5555_5555, 4'd9, 1'b1, 1'b0}},
         '{OP_REDO, '0, 4'h0, 1'b1, '{1'b0, '0, 4'h0, 1'b1, 1'b0}},
         // Out-of-range indexes are stored and returned unchanged.
         '{OP_SNAPSHOT, 64'hAAAA_AAAA_AAAA_AAAA, 4'd10, 1'b0, '0},
         '{OP_SNAPSHOT, 64'h8000_0000_0000_0001, 4'd12, 1'b0, '0},
         '{OP_UNDO, '0, 4'h0, 1'b0, '0},
         '{OP_SNAPSHOT, 64'h0123_4567_89AB_CDEF, 4'hF, 1'b0, '0},
         '{OP_REDO, '0, 4'h0, 1'b0, '0},
         '{OP_UNDO, '0, 4'h0, 1'b0, '0},
         '{OP_UNDO, '0, 4'h0, 1'b0, '0},
         // Clear drops everything and leaves nothing to undo.
         '{OP_CLEAR, '0, 4'h0, 1'b1, '{1'b0, '0, 4'h0, 1'b0, 1'b0}},
         '{OP_UNDO, '0, 4'h0, 1'b1, '{1'b0, '0, 4'h0, 1'b0, 1'b0}},
         '{OP_SNAPSHOT, 64'hFEDC_BA98_7654_3210, 4'd3, 1'b0, '0}
      };

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_cmds[i]) begin
         send_request(directed_cmds[i].op, directed_cmds[i].data, directed_cmds[i].act,
                      directed_cmds[i].typed, directed_cmds[i].want);
      end

      // Fill past the ring size back to back while the response side holds off,
      // so the block backs up and stalls its input.
      sender_gap_max = 0;
      hold_off_req   = HOLD_OFF;
      repeat (FILL_ITEMS) send_random(OP_SNAPSHOT);
      // The ring is full now: redo is refused at the newest position.
      repeat (2) send_random(OP_REDO);
      drain_requests();

      // Random bursts of well-formed edits with some noise mixed in.
      while (random_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            sender_gap_max   = 0;
            receiver_gap_max = 0;
         end else begin
            sender_gap_max   = MAX_IDLE;
            receiver_gap_max = MAX_IDLE;
         end
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            burst_len = $urandom_range(1, 24);
            repeat (burst_len) send_random(OP_SNAPSHOT);
         end else if (kind < 55) begin
            burst_len = $urandom_range(1, 20);
            repeat (burst_len) send_random(OP_UNDO);
         end else if (kind < 70) begin
            burst_len = $urandom_range(1, 20);
            repeat (burst_len) send_random(OP_REDO);
         end else if (kind < 85) begin
            burst_len = $urandom_range(1, 12);
            repeat (burst_len) begin
               r  = $urandom_range(0, 15);
               op = (r == 15) ? OP_CLEAR : op_type'(r % 3);
               send_random(op);
            end
         end else if (kind < 92) begin
            send_random(OP_CLEAR);
         end else begin
            drain_requests();
         end
      end

      drain_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d responses: %0d snapshots, %0d undos, %0d redos, %0d clears.",
               n_responses, n_snap, n_undo, n_redo, n_clear);
      $display("Restores %0d, ring wraps %0d, blocked undo/redo %0d/%0d, input stalls %0d.",
               n_restored, n_wraps, n_undo_blocked, n_redo_blocked, input_stall_cycles);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
